@@ rtl/core/twil_pkg.sv @@
// Shared types, constants and the letter folding function for the trie word store.
`timescale 1ns / 1ps

package twil_pkg;

	localparam int DEF_MAX_NODES = 1024;
	localparam int LETTERS       = 26;
	localparam int LETTER_W      = $clog2(LETTERS);
	localparam int CHAR_W        = 8;
	localparam int NODES_USED_W  = 10;
	localparam int STATUS_W      = 2;
	localparam int OUT_DATA_W    = 16;

	localparam logic [CHAR_W-1:0] LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] UPPER_A = 8'h41;

	// request kinds
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_BAD_CHAR  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_POOL_FULL = 2'd2;

	typedef struct packed {
		logic                ok;
		logic [LETTER_W-1:0] idx;
	} letter_t;

	typedef struct packed {
		logic [NODES_USED_W-1:0] nodes_used;
		logic [STATUS_W-1:0]     status;
		logic                    found;
	} result_t;

	// Fold A..Z onto a..z and return the letter index; non-letters give ok = 0, idx = 0.
	function automatic letter_t fold_letter(input logic [CHAR_W-1:0] c);
		letter_t r;
		r.ok  = 1'b0;
		r.idx = '0;
		if (c >= UPPER_A && c < UPPER_A + CHAR_W'(LETTERS)) begin
			r.ok  = 1'b1;
			r.idx = LETTER_W'(c - UPPER_A);
		end else if (c >= LOWER_A && c < LOWER_A + CHAR_W'(LETTERS)) begin
			r.ok  = 1'b1;
			r.idx = LETTER_W'(c - LOWER_A);
		end
		return r;
	endfunction

endpackage

@@ rtl/core/twil_link_ram.sv @@
// Child link memory (node x letter -> child node) with a zeroing sweep after reset.
`timescale 1ns / 1ps

module twil_link_ram import twil_pkg::*; #(
	parameter int MAX_NODES = DEF_MAX_NODES,
	parameter int NODE_W    = $clog2(MAX_NODES),
	parameter int DEPTH     = MAX_NODES * LETTERS,
	parameter int AW        = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [NODE_W-1:0] rdata,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [NODE_W-1:0] wdata,
	output logic              clear_done
);

	logic [NODE_W-1:0] mem [DEPTH];
	logic [AW-1:0]     clr_q;
	logic              clearing_q;
	logic [NODE_W-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// sweep has the port while clearing; no user write can occur then
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_q] <= '0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata      = rdata_q;
	assign clear_done = !clearing_q;

endmodule

@@ rtl/core/twil_mark_ram.sv @@
// Word-end mark memory, one bit per node.
`timescale 1ns / 1ps

module twil_mark_ram import twil_pkg::*; #(
	parameter int MAX_NODES = DEF_MAX_NODES,
	parameter int NODE_W    = $clog2(MAX_NODES)
) (
	input  logic              clk,
	input  logic              re,
	input  logic [NODE_W-1:0] raddr,
	output logic              rdata,
	input  logic              we,
	input  logic [NODE_W-1:0] waddr,
	input  logic              wdata
);

	logic mem [MAX_NODES];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/twil_ctrl.sv @@
// Per-character sequencer: cursor walk, node allocation, word state and result build.
`timescale 1ns / 1ps

module twil_ctrl import twil_pkg::*; #(
	parameter int MAX_NODES = DEF_MAX_NODES,
	parameter int NODE_W    = $clog2(MAX_NODES),
	parameter int LINK_AW   = $clog2(MAX_NODES * LETTERS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_req,
	input  logic [CHAR_W-1:0]  in_char,
	input  logic               in_last,
	input  logic               clear_done,
	output logic               link_re,
	output logic [LINK_AW-1:0] link_raddr,
	input  logic [NODE_W-1:0]  link_rdata,
	output logic               link_we,
	output logic [LINK_AW-1:0] link_waddr,
	output logic [NODE_W-1:0]  link_wdata,
	output logic               mark_re,
	output logic [NODE_W-1:0]  mark_raddr,
	input  logic               mark_rdata,
	output logic               mark_we,
	output logic [NODE_W-1:0]  mark_waddr,
	output logic               mark_wdata,
	input  logic               out_free,
	output logic               res_valid,
	output result_t            res
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_STEP = 2'd1;
	localparam logic [1:0] S_MARK = 2'd2;
	localparam logic [1:0] S_HOLD = 2'd3;

	logic [1:0]          state_q;
	logic [NODE_W-1:0]   cursor_q;
	logic [NODE_W-1:0]   cnt_q;
	logic                missed_q;
	logic [STATUS_W-1:0] err_q;

	// item captured at accept
	logic                req_s1;
	logic                last_s1;
	logic                ok_s1;
	logic [LINK_AW-1:0]  slot_s1;
	result_t             res_q;

	letter_t             letter;
	logic                accept;
	logic                active;
	logic                need_mark;
	logic [NODE_W-1:0]   new_node;
	logic [NODE_W-1:0]   cursor_d;
	logic [NODE_W-1:0]   cnt_d;
	logic                missed_d;
	logic [STATUS_W-1:0] err_d;
	result_t             res_d;

	assign letter     = fold_letter(in_char);
	assign in_ready   = (state_q == S_IDLE) && clear_done;
	assign accept     = in_valid && in_ready;
	assign link_re    = accept;
	assign link_raddr = LINK_AW'(cursor_q) * LINK_AW'(LETTERS) + LINK_AW'(letter.idx);
	assign active     = (err_q == STAT_OK) && !missed_q;
	assign new_node   = cnt_q + 1'b1;

	always_comb begin
		link_we    = 1'b0;
		link_waddr = slot_s1;
		link_wdata = new_node;
		mark_we    = 1'b0;
		mark_waddr = new_node;
		mark_wdata = last_s1;
		mark_re    = 1'b0;
		mark_raddr = link_rdata;
		need_mark  = 1'b0;
		cursor_d   = cursor_q;
		cnt_d      = cnt_q;
		missed_d   = missed_q;
		err_d      = err_q;
		if (state_q == S_STEP && active) begin
			priority if (!ok_s1) begin
				err_d = STAT_BAD_CHAR;
			end else if (link_rdata != '0) begin
				cursor_d = link_rdata;
				if (last_s1 && req_s1 == REQ_LOOKUP) begin
					mark_re   = 1'b1;
					need_mark = 1'b1;
				end else if (last_s1) begin
					mark_we    = 1'b1;
					mark_waddr = link_rdata;
					mark_wdata = 1'b1;
				end
			end else if (req_s1 == REQ_LOOKUP) begin
				missed_d = 1'b1;
			end else if (cnt_q == NODE_W'(MAX_NODES - 1)) begin
				err_d = STAT_POOL_FULL;
			end else begin
				// fresh node: link it, set its mark (1 only on a clean last insert)
				cnt_d    = new_node;
				cursor_d = new_node;
				link_we  = 1'b1;
				mark_we  = 1'b1;
			end
		end
	end

	always_comb begin
		res_d.found      = 1'b0;
		res_d.status     = err_d;
		res_d.nodes_used = NODES_USED_W'(cnt_d);
		res_valid        = 1'b0;
		res              = res_q;
		unique case (state_q)
			S_IDLE: begin
				res_valid = 1'b0;
			end
			S_STEP: begin
				res_valid = last_s1 && !need_mark && out_free;
				res       = res_d;
			end
			S_MARK: begin
				res_valid = out_free;
				res.found = mark_rdata;
			end
			S_HOLD: begin
				res_valid = out_free;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cursor_q <= '0;
			cnt_q    <= '0;
			missed_q <= 1'b0;
			err_q    <= STAT_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					cnt_q <= cnt_d;
					if (last_s1) begin
						cursor_q <= '0;
						missed_q <= 1'b0;
						err_q    <= STAT_OK;
						if (need_mark) begin
							state_q <= S_MARK;
						end else if (out_free) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_HOLD;
						end
					end else begin
						cursor_q <= cursor_d;
						missed_q <= missed_d;
						err_q    <= err_d;
						state_q  <= S_IDLE;
					end
				end
				S_MARK: begin
					state_q <= out_free ? S_IDLE : S_HOLD;
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= in_req;
			last_s1 <= in_last;
			ok_s1   <= letter.ok;
			slot_s1 <= link_raddr;
		end
		if (state_q == S_STEP && last_s1) begin
			res_q <= res_d;
		end else if (state_q == S_MARK) begin
			res_q.found <= mark_rdata;
		end
	end

	// allocation bumps the pool count by exactly one
	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		link_we |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("node count did not advance on allocation");

	// pool never reaches MAX_NODES (node 0 is the root)
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) < MAX_NODES)
		else $error("node count out of range");

	// a result is only issued when the output register can take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_free)
		else $error("result issued while output register busy");

	// every word ends with the cursor back at the root
	a_cursor_root: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> cursor_q == '0 && err_q == STAT_OK && !missed_q)
		else $error("word state not cleared after result");

endmodule

@@ rtl/core/trie_word_insert_lookup.sv @@
// Top level of the 26-way trie word store: memories, sequencer and output register.
`timescale 1ns / 1ps
//
// Usage
//   Words enter one character per transaction on the s_ channel: s_tdata is the raw
//   character byte (A..Z folded to a..z), s_tuser the request (0 insert, 1 lookup),
//   s_tlast marks the final character. Only the final character produces a result
//   on the m_ channel: found, status (0 ok, 1 non-letter, 2 node pool full) and the
//   count of allocated non-root nodes.
// Character handling
//   Each character takes a child-link memory read at the cursor node, then the
//   decision with an optional link/mark write; no new character is accepted until
//   the decision is done. A lookup that reaches its last character intact also reads
//   the word-end mark. The result is then registered on m_ once the register is free.
// Reset
//   arst_n clears the control state; afterwards the link memory is zeroed one entry
//   per cycle, MAX_NODES*26 entries (26624 at the default), with s_tready held low.
// Back-pressure
//   The result sits in an output register; the next word's characters are accepted
//   while it waits. A further result waits in the sequencer until m_tready frees the
//   register, and no new character is taken meanwhile.
//
module trie_word_insert_lookup import twil_pkg::*; #(
	parameter int MAX_NODES = DEF_MAX_NODES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [CHAR_W-1:0]     s_tdata,   // [7:0] char_code
	input  logic                  s_tuser,   // [0] req_type
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // [0] found, [2:1] status, [12:3] nodes_used
);

	localparam int NODE_W  = $clog2(MAX_NODES);
	localparam int LINK_AW = $clog2(MAX_NODES * LETTERS);

	logic               link_re;
	logic [LINK_AW-1:0] link_raddr;
	logic [NODE_W-1:0]  link_rdata;
	logic               link_we;
	logic [LINK_AW-1:0] link_waddr;
	logic [NODE_W-1:0]  link_wdata;
	logic               clear_done;
	logic               mark_re;
	logic [NODE_W-1:0]  mark_raddr;
	logic               mark_rdata;
	logic               mark_we;
	logic [NODE_W-1:0]  mark_waddr;
	logic               mark_wdata;
	logic               out_free;
	logic               res_valid;
	result_t            res;

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	twil_link_ram #(
		.MAX_NODES (MAX_NODES)
	) u_link_ram (
		.clk        (clk),
		.arst_n     (arst_n),
		.re         (link_re),
		.raddr      (link_raddr),
		.rdata      (link_rdata),
		.we         (link_we),
		.waddr      (link_waddr),
		.wdata      (link_wdata),
		.clear_done (clear_done)
	);

	twil_mark_ram #(
		.MAX_NODES (MAX_NODES)
	) u_mark_ram (
		.clk   (clk),
		.re    (mark_re),
		.raddr (mark_raddr),
		.rdata (mark_rdata),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata)
	);

	twil_ctrl #(
		.MAX_NODES (MAX_NODES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_req     (s_tuser),
		.in_char    (s_tdata),
		.in_last    (s_tlast),
		.clear_done (clear_done),
		.link_re    (link_re),
		.link_raddr (link_raddr),
		.link_rdata (link_rdata),
		.link_we    (link_we),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.mark_re    (mark_re),
		.mark_raddr (mark_raddr),
		.mark_rdata (mark_rdata),
		.mark_we    (mark_we),
		.mark_waddr (mark_waddr),
		.mark_wdata (mark_wdata),
		.out_free   (out_free),
		.res_valid  (res_valid),
		.res        (res)
	);

	// output register: free when empty or being drained this cycle
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_tdata_q <= OUT_DATA_W'({res.nodes_used, res.status, res.found});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ verif/trie_word_insert_lookup_tb.sv @@
// Self-checking testbench for the trie word store: directed words, random words, stalls, pool fill.
`timescale 1ns / 1ps

module trie_word_insert_lookup_tb;
	import twil_pkg::*;

	localparam int TRIE_NODES       = DEF_MAX_NODES;
	localparam int CYCLE_LIMIT      = 500000;   // clear pass plus a slow run, several times over
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int END_SETTLE       = 16;
	localparam int MAX_REPORTS      = 10;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_COIN,
		RX_ONE_IN_FOUR,
		RX_MOSTLY
	} rx_mode_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [CHAR_W-1:0]     s_tdata  = '0;      // [7:0] char_code
	logic                  s_tuser  = 1'b0;    // [0] req_type
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;            // [0] found, [2:1] status, [12:3] nodes_used

	// shadow trie
	int unsigned         link_mem [TRIE_NODES*LETTERS];
	bit                  word_end [TRIE_NODES];
	int unsigned         nodes_alloc = 0;
	int unsigned         cur_node    = 0;
	bit                  cur_missed  = 1'b0;
	logic [STATUS_W-1:0] cur_err     = STAT_OK;

	result_t     word_results_due[$];
	string       stored_words[$];
	int          chars_walked      = 0;
	int          mismatches        = 0;
	int          cycle_count       = 0;
	int          burst_left        = 0;
	bit          sender_steady     = 1'b0;
	bit          long_hold_request = 1'b0;
	int          hold_left         = 0;
	int unsigned rx_tick           = 0;
	rx_mode_t    rx_mode           = RX_ALWAYS;

	trie_word_insert_lookup #(
		.MAX_NODES(TRIE_NODES)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("trie_word_insert_lookup_tb: FAIL");
			$finish;
		end
	end

	// Walk one character through the shadow trie. acted is low when the word
	// already missed or failed and the character is ignored.
	function automatic void walk_char(input logic req, input logic [CHAR_W-1:0] c,
		input logic last, output bit acted, output bit has_res, output result_t res);
		bit          is_letter;
		int unsigned idx;
		int unsigned slot;
		int unsigned child;
		acted   = (cur_err == STAT_OK) && !cur_missed;
		has_res = last;
		res     = '0;
		if (acted) begin
			is_letter = 1'b1;
			idx       = 0;
			if (c >= UPPER_A && c < UPPER_A + LETTERS)
				idx = c - UPPER_A;
			else if (c >= LOWER_A && c < LOWER_A + LETTERS)
				idx = c - LOWER_A;
			else
				is_letter = 1'b0;

			if (!is_letter) begin
				cur_err = STAT_BAD_CHAR;
			end else begin
				slot  = cur_node * LETTERS + idx;
				child = link_mem[slot];
				if (child != 0) begin
					cur_node = child;
				end else if (req == REQ_LOOKUP) begin
					cur_missed = 1'b1;
				end else if (nodes_alloc + 1 >= TRIE_NODES) begin
					cur_err = STAT_POOL_FULL;
				end else begin
					nodes_alloc++;
					link_mem[slot]        = nodes_alloc;
					word_end[nodes_alloc] = 1'b0;
					cur_node              = nodes_alloc;
				end
			end
		end
		if (last) begin
			// the last character's own request decides between mark and check
			if (cur_err == STAT_OK && !cur_missed) begin
				if (req == REQ_LOOKUP)
					res.found = word_end[cur_node];
				else
					word_end[cur_node] = 1'b1;
			end
			res.status     = cur_err;
			res.nodes_used = NODES_USED_W'(nodes_alloc);
			cur_node       = 0;
			cur_missed     = 1'b0;
			cur_err        = STAT_OK;
		end
	endfunction

	function automatic void note_mismatch(input string field, input int unsigned want,
		input int unsigned got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endfunction

	function automatic string make_word(input int min_len, input int max_len, input int span);
		string w;
		int    n;
		w = "";
		n = $urandom_range(min_len, max_len);
		repeat (n)
			w = $sformatf("%s%c", w, LOWER_A + $urandom_range(0, span - 1));
		return w;
	endfunction

	// One character transaction. Bursts of random length alternate with idle gaps
	// unless the sender is in a steady stretch.
	task automatic send_char(input logic req, input logic [CHAR_W-1:0] c, input logic last);
		bit      acted;
		bit      has_res;
		result_t res;
		if (!sender_steady && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tuser  <= req;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		walk_char(req, c, last, acted, has_res, res);
		if (has_res)
			word_results_due = {word_results_due, res};
		if (acted)
			chars_walked++;
	endtask

	// Send a word; some letters go upper case, some bytes are replaced by noise and
	// some characters carry the other request type.
	task automatic send_word(input logic req, input string w, input int case_pct,
		input int noise_pct, input int mix_pct);
		logic [CHAR_W-1:0] c;
		logic              r;
		for (int i = 0; i < w.len(); i++) begin
			c = w[i];
			if (c >= LOWER_A && c < LOWER_A + LETTERS && $urandom_range(0, 99) < case_pct)
				c = c - LOWER_A + UPPER_A;
			if ($urandom_range(0, 99) < noise_pct)
				c = $urandom_range(0, 255);
			r = ($urandom_range(0, 99) < mix_pct) ? ~req : req;
			send_char(r, c, i == w.len() - 1);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (word_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed_cases();
		send_word(REQ_LOOKUP, "a", 0, 0, 0);        // empty trie
		send_word(REQ_INSERT, "Cat", 0, 0, 0);      // upper case folds
		send_word(REQ_LOOKUP, "CAT", 0, 0, 0);
		send_word(REQ_LOOKUP, "ca", 0, 0, 0);       // prefix without word-end mark
		// partial insert: 'a' takes a node, then the non-letter stops the word
		send_char(REQ_INSERT, LOWER_A, 1'b0);
		send_char(REQ_INSERT, 8'hff, 1'b1);
		send_char(REQ_INSERT, 8'h00, 1'b1);
		// bytes just outside both letter ranges
		send_char(REQ_LOOKUP, UPPER_A - 8'd1, 1'b1);
		send_char(REQ_LOOKUP, UPPER_A + 8'd26, 1'b1);
		send_char(REQ_INSERT, LOWER_A - 8'd1, 1'b1);
		send_char(REQ_INSERT, LOWER_A + 8'd26, 1'b1);
		// mixed request types, last one an insert: mark is set
		send_char(REQ_INSERT, "c", 1'b0);
		send_char(REQ_LOOKUP, "a", 1'b0);
		send_char(REQ_INSERT, "Z", 1'b1);
		send_word(REQ_LOOKUP, "caz", 0, 0, 0);
		// lookup miss followed by an insert on the last character: no mark
		send_char(REQ_LOOKUP, "q", 1'b0);
		send_char(REQ_INSERT, "b", 1'b1);
		wait_drained();
	endtask

	task automatic test_random_words(input int target);
		int    start;
		string w;
		logic  req;
		int    pick;
		start = chars_walked;
		while (chars_walked - start < target) begin
			if ($urandom_range(0, 29) == 0)
				sender_steady = !sender_steady;
			req = $urandom_range(0, 1) ? REQ_LOOKUP : REQ_INSERT;
			if (req == REQ_LOOKUP && stored_words.size() > 0 && $urandom_range(0, 99) < 60) begin
				w    = stored_words[$urandom_range(0, stored_words.size() - 1)];
				pick = $urandom_range(0, 9);
				if (pick < 2 && w.len() > 1)
					w = w.substr(0, w.len() - 2);
				else if (pick == 2)
					w = {w, make_word(1, 1, 26)};
			end else begin
				w = make_word(1, ($urandom_range(0, 9) == 0) ? 12 : 6,
					($urandom_range(0, 4) == 0) ? 26 : 5);
			end
			if (req == REQ_INSERT && stored_words.size() < 512)
				stored_words = {stored_words, w};
			send_word(req, w, 30, 4, 5);
		end
		sender_steady = 1'b0;
		wait_drained();
	endtask

	// Results back up behind a long receiver hold while the sender keeps offering
	// transactions, so the input has to stall.
	task automatic test_output_stall();
		sender_steady     = 1'b1;
		long_hold_request = 1'b1;
		repeat (40)
			send_word($urandom_range(0, 1) ? REQ_LOOKUP : REQ_INSERT, make_word(1, 2, 5),
				30, 0, 0);
		sender_steady = 1'b0;
		wait_drained();
	endtask

	task automatic test_pool_exhaustion();
		string w;
		int    guard;
		guard = 0;
		while (nodes_alloc + 1 < TRIE_NODES && guard < 400) begin
			w = make_word(16, 32, 26);
			stored_words = {stored_words, w};
			send_word(REQ_INSERT, w, 20, 0, 0);
			guard++;
		end
		// pool now full: new paths fail, existing ones still work
		repeat (3)
			send_word(REQ_INSERT, make_word(3, 8, 26), 20, 0, 0);
		// a new ten-letter insert, then a non-letter sent as a one-character word
		send_word(REQ_INSERT, make_word(10, 10, 26), 0, 0, 0);
		send_char(REQ_INSERT, 8'h00, 1'b1);
		repeat (2) begin
			w = stored_words[$urandom_range(0, stored_words.size() - 1)];
			send_word($urandom_range(0, 1) ? REQ_LOOKUP : REQ_INSERT, w, 30, 0, 0);
		end
		wait_drained();
	endtask

	// receiver: changing ready pattern, plus one long hold on request
	always @(posedge clk) begin : drive_result_ready
		if (long_hold_request) begin
			long_hold_request = 1'b0;
			hold_left         = LONG_HOLD_CYCLES;
		end
		rx_tick++;
		if (rx_tick % 48 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS:      m_tready <= 1'b1;
				RX_COIN:        m_tready <= $urandom_range(0, 1);
				RX_ONE_IN_FOUR: m_tready <= (rx_tick % 4 == 0);
				default:        m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// each result transaction against the oldest expectation
	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(result_t)-1:0];
			if (word_results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with none expected, data %h", $time, m_tdata);
			end else begin
				want = word_results_due.pop_front();
				if (got.found !== want.found)
					note_mismatch("found", want.found, got.found);
				if (got.status !== want.status)
					note_mismatch("status", want.status, got.status);
				if (got.nodes_used !== want.nodes_used)
					note_mismatch("nodes_used", want.nodes_used, got.nodes_used);
				if (m_tdata[OUT_DATA_W-1:$bits(result_t)] !== '0)
					note_mismatch("padding", 0, m_tdata[OUT_DATA_W-1:$bits(result_t)]);
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_words(100);
		test_output_stall();
		test_pool_exhaustion();

		wait_drained();
		repeat (END_SETTLE) @(posedge clk);
		if (word_results_due.size() != 0) begin
			mismatches++;
			$display("%0d expected results never arrived", word_results_due.size());
		end
		if (mismatches == 0)
			$display("trie_word_insert_lookup_tb: PASS");
		else
			$display("trie_word_insert_lookup_tb: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/twil_pkg.sv
rtl/core/twil_link_ram.sv
rtl/core/twil_mark_ram.sv
rtl/core/twil_ctrl.sv
rtl/core/trie_word_insert_lookup.sv
verif/trie_word_insert_lookup_tb.sv
